// ===== design/ibt_pkg.sv =====
`default_nettype none

package ibt_pkg;

	typedef enum logic [1:0] {
		ST_BOOKED  = 2'd0,
		ST_OVERLAP = 2'd1,
		ST_FULL    = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	typedef struct packed {
		logic [31:0] start_time;
		logic [31:0] end_time;
	} req_item_t;

	typedef struct packed {
		logic        accepted;
		status_t     status;
		logic [10:0] entries_used;
	} rsp_item_t;

endpackage

`default_nettype wire

// ===== design/interval_booking_table_unit.sv =====
// Interval booking table: stores non-overlapping half-open intervals [start, end).
// Request channel (req_valid / req_stall / req) brings one interval per item;
// response channel (rsp_valid / rsp_stall / rsp) returns one result item for each:
// accepted flag, status and the number of stored intervals after the request.
// An item is taken at a clock edge where valid is high and stall is low.
// req_stall is high whenever a request is in progress or its result is waiting.
// An empty or inverted request goes straight to its result without a scan.
// Any other request scans the stored intervals one per cycle through a single
// memory read port and one overlap comparator, then decides and registers its
// result; no new request is taken until the result item has left.
// The next request is taken in the cycle after the result item leaves.
// While rsp_stall is high the result is held unchanged and no request is taken.
// Reset (arst_n low, asynchronous) empties the table at once; entry storage is
// not cleared, since only entries below the count are ever read.
`default_nettype none

module interval_booking_table_unit #(
	parameter int CAPACITY   = 1024,
	parameter int TIME_WIDTH = 32
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      req_valid,
	output logic                     req_stall,
	input  wire ibt_pkg::req_item_t  req,
	output logic                     rsp_valid,
	input  wire                      rsp_stall,
	output ibt_pkg::rsp_item_t       rsp
);

	import ibt_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_DECIDE = 4'b0100,
		S_OUT    = 4'b1000
	} state_t;

	state_t state_q;

	logic [2*TIME_WIDTH-1:0] mem [CAPACITY];
	logic [2*TIME_WIDTH-1:0] rdata_q;
	logic                    rvld_q;

	logic [TIME_WIDTH-1:0] start_q;
	logic [TIME_WIDTH-1:0] end_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         idx_q;
	logic                  hit_q;
	rsp_item_t             rsp_q;

	logic [TIME_WIDTH+31:0] start_ext;
	logic [TIME_WIDTH+31:0] end_ext;
	logic [TIME_WIDTH-1:0]  req_start;
	logic [TIME_WIDTH-1:0]  req_end;
	logic [TIME_WIDTH-1:0]  rd_start;
	logic [TIME_WIDTH-1:0]  rd_end;
	logic                   overlap;
	logic                   issue;
	logic                   full;
	logic                   req_take;
	logic [CW+10:0]         count_ext;
	logic [CW+10:0]         count_inc_ext;
	logic [CW-1:0]          count_inc;

	assign start_ext     = {{TIME_WIDTH{1'b0}}, req.start_time};
	assign end_ext       = {{TIME_WIDTH{1'b0}}, req.end_time};
	assign req_start     = start_ext[TIME_WIDTH-1:0];
	assign req_end       = end_ext[TIME_WIDTH-1:0];
	assign rd_start      = rdata_q[2*TIME_WIDTH-1:TIME_WIDTH];
	assign rd_end        = rdata_q[TIME_WIDTH-1:0];
	assign overlap       = (start_q < rd_end) && (rd_start < end_q);
	assign issue         = (state_q == S_SCAN) && (idx_q != count_q);
	assign full          = (count_q == CW'(CAPACITY));
	assign count_inc     = count_q + 1'b1;
	assign count_ext     = {11'd0, count_q};
	assign count_inc_ext = {11'd0, count_inc};

	assign req_stall = (state_q != S_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign rsp_valid = (state_q == S_OUT);
	assign rsp       = rsp_q;

	always_ff @(posedge clk) begin
		if (issue) begin
			rdata_q <= mem[idx_q[AW-1:0]];
		end
		if (state_q == S_DECIDE && !hit_q && !full) begin
			mem[count_q[AW-1:0]] <= {start_q, end_q};
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			start_q <= req_start;
			end_q   <= req_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			hit_q   <= 1'b0;
			rvld_q  <= 1'b0;
			rsp_q   <= '0;
		end else begin
			rvld_q <= issue;
			unique case (state_q)
				S_IDLE: begin
					if (req_take) begin
						idx_q <= '0;
						hit_q <= 1'b0;
						if (req_end <= req_start) begin
							rsp_q.accepted     <= 1'b0;
							rsp_q.status       <= ST_EMPTY;
							rsp_q.entries_used <= count_ext[10:0];
							state_q            <= S_OUT;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (issue) begin
						idx_q <= idx_q + 1'b1;
					end
					if (rvld_q && overlap) begin
						hit_q <= 1'b1;
					end
					if (!issue && !rvld_q) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (hit_q) begin
						rsp_q.accepted     <= 1'b0;
						rsp_q.status       <= ST_OVERLAP;
						rsp_q.entries_used <= count_ext[10:0];
					end else if (full) begin
						rsp_q.accepted     <= 1'b0;
						rsp_q.status       <= ST_FULL;
						rsp_q.entries_used <= count_ext[10:0];
					end else begin
						count_q            <= count_inc;
						rsp_q.accepted     <= 1'b1;
						rsp_q.status       <= ST_BOOKED;
						rsp_q.entries_used <= count_inc_ext[10:0];
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!rsp_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (idx_q <= count_q))
		else $error("scan index past entry count");

	a_rvld_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rvld_q |-> (state_q == S_SCAN))
		else $error("read data valid outside scan");

	a_book_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE && !hit_q && !full) |=>
		(count_q == $past(count_inc) && rsp_valid && rsp.accepted))
		else $error("booking did not advance entry count");

	a_accept_status: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.accepted) |-> (rsp.status == ST_BOOKED))
		else $error("accepted item without booked status");
`endif

endmodule

`default_nettype wire
